// File: design/jfhs_pkg.sv
// ----------------------------------------------------------------------------
// jfhs_pkg
// Shared types and constants for the JPEG frame header scanner: payload
// structs, controller/datapath command and status bundles, marker codes.
// ----------------------------------------------------------------------------
package jfhs_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int HW_W   = 2 * WORD_W;       // height * width
    localparam int SIZE_W = 40;               // raw size and window registers
    localparam int CFG_DW = 64;               // APB data width
    localparam int CFG_AW = 4;                // two registers, 64-bit words, at 0 and 8

    // Register indexes (by paddr[3])
    localparam logic REG_MIN_RAW = 1'b0;
    localparam logic REG_MAX_RAW = 1'b1;

    // Reset values of the offload window
    localparam logic [SIZE_W-1:0] MIN_RAW_RESET = SIZE_W'(230400);
    localparam logic [SIZE_W-1:0] MAX_RAW_RESET = SIZE_W'(2621440);

    // Marker codes
    localparam logic [BYTE_W-1:0] MRK_PREFIX   = 8'hFF;
    localparam logic [BYTE_W-1:0] MRK_SOF_LO   = 8'hC0;
    localparam logic [BYTE_W-1:0] MRK_SOF_HI   = 8'hCF;
    localparam logic [BYTE_W-1:0] MRK_DHT      = 8'hC4;
    localparam logic [BYTE_W-1:0] MRK_JPG      = 8'hC8;
    localparam logic [BYTE_W-1:0] MRK_DAC      = 8'hCC;
    localparam logic [BYTE_W-1:0] MRK_SOI      = 8'hD8;
    localparam logic [BYTE_W-1:0] MRK_TEM      = 8'h01;
    localparam logic [BYTE_W-1:0] MRK_RST_LO   = 8'hD0;
    localparam logic [BYTE_W-1:0] MRK_RST_HI   = 8'hD7;

    // Frame header byte offsets (after the marker code)
    localparam logic [2:0] HDR_OFS_H_HI = 3'd3;
    localparam logic [2:0] HDR_OFS_H_LO = 3'd4;
    localparam logic [2:0] HDR_OFS_W_HI = 3'd5;
    localparam logic [2:0] HDR_OFS_W_LO = 3'd6;
    localparam logic [2:0] HDR_OFS_COMP = 3'd7;

    // Segment length at or below which nothing is skipped
    localparam logic [WORD_W-1:0] LEN_BIAS = 16'd2;

    // Input request
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } jfhs_in_t;

    // Result request
    typedef struct packed {
        logic [SIZE_W-1:0] raw_size;
        logic              found;
        logic              in_range;
    } jfhs_out_t;

    // Which header word byte to capture
    typedef enum logic [2:0] {
        HDR_NONE,
        HDR_H_HI,
        HDR_H_LO,
        HDR_W_HI,
        HDR_W_LO
    } hdr_sel_t;

    // Controller -> datapath
    typedef struct packed {
        logic     len_hi_load;
        logic     skip_load;
        logic     skip_dec;
        hdr_sel_t hdr_sel;
        logic     mul_start;   // h*w and component byte into stage registers
        logic     prod;        // final product into size register, found set
        logic     size_zero;   // not-found result
        logic     out_load;    // result into output register
    } jfhs_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic is_prefix;
        logic is_frame_start;
        logic is_standalone;
        logic len_gt_bias;
        logic skip_one;
        logic out_free;
    } jfhs_sts_t;

endpackage

// File: design/jpeg_frame_header_scanner.sv
// ----------------------------------------------------------------------------
// jpeg_frame_header_scanner
// Scans a JPEG byte stream for the frame header and reports the raw image
// size and whether it falls in the configured offload window.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle on the s_ channel and returns exactly one
// result per file on the m_ channel: raw_size = height * width * components
// with found set once a frame-start header has been read, or raw_size 0 and
// found clear if the file ends first; in_range compares raw_size against the
// min/max window registers (APB at 0x0 and 0x8, inclusive bounds). Bytes are
// taken at one per cycle; the byte that completes the header holds s_ready
// low through the 16x16 multiplier stage and the 32x8 stage into the size
// register, and a last byte with no header found holds it low while the
// result is loaded; both last longer while an earlier result awaits m_ready.
// After a header is reported the rest of the file is drained at one byte per
// cycle; the parser restarts after every byte flagged last_byte.
// ----------------------------------------------------------------------------
module jpeg_frame_header_scanner (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input requests
    input  logic                         s_valid,
    output logic                         s_ready,
    input  jfhs_pkg::jfhs_in_t           s_data,
    // Result requests
    output logic                         m_valid,
    input  logic                         m_ready,
    output jfhs_pkg::jfhs_out_t          m_data,
    // Configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jfhs_pkg::CFG_AW-1:0]  paddr,
    input  logic [jfhs_pkg::CFG_DW-1:0]  pwdata,
    output logic [jfhs_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);

    logic [jfhs_pkg::SIZE_W-1:0] min_raw_size;
    logic [jfhs_pkg::SIZE_W-1:0] max_raw_size;
    jfhs_pkg::jfhs_cmd_t         cmd;
    jfhs_pkg::jfhs_sts_t         sts;

    jfhs_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .min_raw_size (min_raw_size),
        .max_raw_size (max_raw_size)
    );

    jfhs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .last_byte (s_data.last_byte),
        .sts       (sts),
        .cmd       (cmd)
    );

    jfhs_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .data_byte    (s_data.data_byte),
        .cmd          (cmd),
        .sts          (sts),
        .min_raw_size (min_raw_size),
        .max_raw_size (max_raw_size),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    // A not-found result always carries a zero size
    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.found || (m_data.raw_size == '0)))
        else $error("not-found result with nonzero size");

    // A result is only loaded while the input side is held off
    a_load_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result loaded while input was accepted");

    // The command bundle never loads a result and takes a byte together
    a_load_excl_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !s_ready)
        else $error("output load overlaps input accept");

endmodule

// File: design/jfhs_regs.sv
// ----------------------------------------------------------------------------
// jfhs_regs
// APB register file holding the offload window bounds.
// ----------------------------------------------------------------------------
module jfhs_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jfhs_pkg::CFG_AW-1:0]  paddr,
    input  logic [jfhs_pkg::CFG_DW-1:0]  pwdata,
    output logic [jfhs_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready,
    output logic [jfhs_pkg::SIZE_W-1:0]  min_raw_size,
    output logic [jfhs_pkg::SIZE_W-1:0]  max_raw_size
);

    logic [jfhs_pkg::SIZE_W-1:0] min_raw_reg;
    logic [jfhs_pkg::SIZE_W-1:0] max_raw_reg;
    logic                        wr_en;
    logic                        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3];
    assign wr_en   = psel && penable && pwrite;

    // Write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_raw_reg <= jfhs_pkg::MIN_RAW_RESET;
            max_raw_reg <= jfhs_pkg::MAX_RAW_RESET;
        end else if (wr_en) begin
            if (reg_idx == jfhs_pkg::REG_MIN_RAW) begin
                min_raw_reg <= pwdata[jfhs_pkg::SIZE_W-1:0];
            end else begin
                max_raw_reg <= pwdata[jfhs_pkg::SIZE_W-1:0];
            end
        end
    end

    // Read mux
    always_comb begin
        if (reg_idx == jfhs_pkg::REG_MIN_RAW) begin
            prdata = jfhs_pkg::CFG_DW'(min_raw_reg);
        end else begin
            prdata = jfhs_pkg::CFG_DW'(max_raw_reg);
        end
    end

    assign min_raw_size = min_raw_reg;
    assign max_raw_size = max_raw_reg;

endmodule

// File: design/jfhs_dp.sv
// ----------------------------------------------------------------------------
// jfhs_dp
// Datapath: byte classification, segment length and skip counter, header
// words, two-stage size multiplier, window compare and output register.
// ----------------------------------------------------------------------------
module jfhs_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [jfhs_pkg::BYTE_W-1:0]  data_byte,
    input  jfhs_pkg::jfhs_cmd_t          cmd,
    output jfhs_pkg::jfhs_sts_t          sts,
    input  logic [jfhs_pkg::SIZE_W-1:0]  min_raw_size,
    input  logic [jfhs_pkg::SIZE_W-1:0]  max_raw_size,
    output logic                         m_valid,
    input  logic                         m_ready,
    output jfhs_pkg::jfhs_out_t          m_data
);

    logic [jfhs_pkg::BYTE_W-1:0] len_hi_reg;
    logic [jfhs_pkg::WORD_W-1:0] skip_reg;
    logic [jfhs_pkg::WORD_W-1:0] height_reg;
    logic [jfhs_pkg::WORD_W-1:0] width_reg;
    logic [jfhs_pkg::HW_W-1:0]   hw_reg;
    logic [jfhs_pkg::BYTE_W-1:0] comp_reg;
    logic [jfhs_pkg::SIZE_W-1:0] size_reg;
    logic                        found_reg;
    jfhs_pkg::jfhs_out_t         out_reg;
    logic                        m_valid_reg;

    logic [jfhs_pkg::WORD_W-1:0] seg_len;
    logic                        in_window;

    // Status: marker classification of the incoming byte, length and skip tests, output free
    always_comb begin
        sts.is_prefix      = (data_byte == jfhs_pkg::MRK_PREFIX);
        sts.is_frame_start = (data_byte >= jfhs_pkg::MRK_SOF_LO)
                          && (data_byte <= jfhs_pkg::MRK_SOF_HI)
                          && (data_byte != jfhs_pkg::MRK_DHT)
                          && (data_byte != jfhs_pkg::MRK_JPG)
                          && (data_byte != jfhs_pkg::MRK_DAC);
        sts.is_standalone  = (data_byte == jfhs_pkg::MRK_SOI)
                          || (data_byte == jfhs_pkg::MRK_TEM)
                          || ((data_byte >= jfhs_pkg::MRK_RST_LO)
                              && (data_byte <= jfhs_pkg::MRK_RST_HI));
        sts.len_gt_bias    = (seg_len > jfhs_pkg::LEN_BIAS);
        sts.skip_one       = (skip_reg == jfhs_pkg::WORD_W'(1));
        sts.out_free       = !m_valid_reg || m_ready;
    end

    assign seg_len = {len_hi_reg, data_byte};

    // Segment length and skip counter
    always_ff @(posedge aclk) begin
        if (cmd.len_hi_load) begin
            len_hi_reg <= data_byte;
        end
        if (cmd.skip_load) begin
            skip_reg <= seg_len - jfhs_pkg::LEN_BIAS;
        end else if (cmd.skip_dec) begin
            skip_reg <= skip_reg - jfhs_pkg::WORD_W'(1);
        end
    end

    // Frame header words, big-endian
    always_ff @(posedge aclk) begin
        unique case (cmd.hdr_sel)
            jfhs_pkg::HDR_H_HI: height_reg <= {data_byte, jfhs_pkg::BYTE_W'(0)};
            jfhs_pkg::HDR_H_LO: height_reg <= {height_reg[jfhs_pkg::WORD_W-1:jfhs_pkg::BYTE_W],
                                               data_byte};
            jfhs_pkg::HDR_W_HI: width_reg  <= {data_byte, jfhs_pkg::BYTE_W'(0)};
            jfhs_pkg::HDR_W_LO: width_reg  <= {width_reg[jfhs_pkg::WORD_W-1:jfhs_pkg::BYTE_W],
                                               data_byte};
            default: ;
        endcase
    end

    // Size multiplier: 16x16 stage, then 32x8 stage
    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            hw_reg   <= jfhs_pkg::HW_W'(height_reg) * jfhs_pkg::HW_W'(width_reg);
            comp_reg <= data_byte;
        end
        if (cmd.prod) begin
            size_reg  <= jfhs_pkg::SIZE_W'(hw_reg) * jfhs_pkg::SIZE_W'(comp_reg);
            found_reg <= 1'b1;
        end else if (cmd.size_zero) begin
            size_reg  <= '0;
            found_reg <= 1'b0;
        end
    end

    assign in_window = (size_reg >= min_raw_size) && (size_reg <= max_raw_size);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_reg.raw_size <= size_reg;
            out_reg.found    <= found_reg;
            out_reg.in_range <= in_window;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: design/jfhs_ctrl.sv
// ----------------------------------------------------------------------------
// jfhs_ctrl
// Parse controller: marker hunt, segment skip, frame header walk and
// result sequencing. Drives the datapath through the command bundle.
// ----------------------------------------------------------------------------
module jfhs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 last_byte,
    input  jfhs_pkg::jfhs_sts_t  sts,
    output jfhs_pkg::jfhs_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_LEAD,
        ST_HUNT,
        ST_MARK,
        ST_LENHI,
        ST_LENLO,
        ST_SKIP,
        ST_HEADER,
        ST_DONE,
        ST_PROD,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic       lead_seen_reg, lead_seen_next;
    logic [2:0] hdr_ofs_reg, hdr_ofs_next;
    logic       last_pend_reg, last_pend_next;
    logic       accept;
    logic       hdr_done;

    assign s_ready  = (state_reg != ST_PROD) && (state_reg != ST_EMIT);
    assign accept   = s_valid && s_ready;
    assign hdr_done = (state_reg == ST_HEADER) && (hdr_ofs_reg == jfhs_pkg::HDR_OFS_COMP);

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        lead_seen_next = lead_seen_reg;
        hdr_ofs_next   = hdr_ofs_reg;
        last_pend_next = last_pend_reg;
        cmd            = '0;
        cmd.hdr_sel    = jfhs_pkg::HDR_NONE;

        unique case (state_reg)
            ST_LEAD: begin
                if (accept) begin
                    lead_seen_next = 1'b1;
                    if (lead_seen_reg) begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_HUNT: begin
                if (accept && sts.is_prefix) begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK: begin
                if (accept) begin
                    priority if (sts.is_frame_start) begin
                        hdr_ofs_next = '0;
                        state_next   = ST_HEADER;
                    end else if (sts.is_standalone) begin
                        state_next = ST_HUNT;
                    end else begin
                        state_next = ST_LENHI;
                    end
                end
            end
            ST_LENHI: begin
                if (accept) begin
                    cmd.len_hi_load = 1'b1;
                    state_next      = ST_LENLO;
                end
            end
            ST_LENLO: begin
                if (accept) begin
                    if (sts.len_gt_bias) begin
                        cmd.skip_load = 1'b1;
                        state_next    = ST_SKIP;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_SKIP: begin
                if (accept) begin
                    cmd.skip_dec = 1'b1;
                    if (sts.skip_one) begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_HEADER: begin
                if (accept) begin
                    unique case (hdr_ofs_reg)
                        jfhs_pkg::HDR_OFS_H_HI: cmd.hdr_sel = jfhs_pkg::HDR_H_HI;
                        jfhs_pkg::HDR_OFS_H_LO: cmd.hdr_sel = jfhs_pkg::HDR_H_LO;
                        jfhs_pkg::HDR_OFS_W_HI: cmd.hdr_sel = jfhs_pkg::HDR_W_HI;
                        jfhs_pkg::HDR_OFS_W_LO: cmd.hdr_sel = jfhs_pkg::HDR_W_LO;
                        default:                cmd.hdr_sel = jfhs_pkg::HDR_NONE;
                    endcase
                    if (hdr_done) begin
                        cmd.mul_start  = 1'b1;
                        last_pend_next = last_byte;
                        state_next     = ST_PROD;
                    end else begin
                        hdr_ofs_next = hdr_ofs_reg + 3'd1;
                    end
                end
            end
            ST_DONE: ;
            ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = last_pend_reg ? ST_LEAD : ST_DONE;
                end
            end
            default: state_next = ST_LEAD;
        endcase

        // End of file: restart the parse, not-found result unless reported
        if (accept && last_byte) begin
            lead_seen_next = 1'b0;
            hdr_ofs_next   = '0;
            if (state_reg == ST_DONE) begin
                state_next = ST_LEAD;
            end else if (!hdr_done) begin
                cmd.size_zero  = 1'b1;
                last_pend_next = 1'b1;
                state_next     = ST_EMIT;
            end
        end
    end

    // State and registered controls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LEAD;
            lead_seen_reg <= 1'b0;
            hdr_ofs_reg   <= '0;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lead_seen_reg <= lead_seen_next;
            hdr_ofs_reg   <= hdr_ofs_next;
            last_pend_reg <= last_pend_next;
        end
    end

endmodule
